// ===== rtl/rotate_translate_perspective_core_defines.svh =====
// Assertion macros shared by the core.
`ifndef ROTATE_TRANSLATE_PERSPECTIVE_CORE_DEFINES_SVH
`define ROTATE_TRANSLATE_PERSPECTIVE_CORE_DEFINES_SVH

// Concurrent property checked on every rising clock edge outside reset.
`define RTP_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Next-cycle implication checked outside reset.
`define RTP_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/rtp_pkg.sv =====
package rtp_pkg;

  localparam int unsigned RecipDepth = 257;

  // Register indexes of the configuration port.
  typedef enum logic [2:0] {
    REG_ROW0  = 3'd0,
    REG_ROW1  = 3'd1,
    REG_ROW2  = 3'd2,
    REG_TXY   = 3'd3,
    REG_TZ    = 3'd4,
    REG_PROJ  = 3'd5,
    REG_DCUE  = 3'd6,
    REG_NONE  = 3'd7
  } reg_idx_e;

  localparam logic [16:0] QuotMax = 17'h1FFFF;

  // Flag bit positions.
  localparam int unsigned FlIr1   = 6;
  localparam int unsigned FlIr2   = 7;
  localparam int unsigned FlIr3   = 8;
  localparam int unsigned FlSz    = 9;
  localparam int unsigned FlDiv   = 10;
  localparam int unsigned FlMac0P = 11;
  localparam int unsigned FlMac0N = 12;
  localparam int unsigned FlSx    = 13;
  localparam int unsigned FlSy    = 14;
  localparam int unsigned FlIr0   = 15;

  // Configuration bundle shared by the stages.
  typedef struct packed {
    logic [47:0] row0;
    logic [47:0] row1;
    logic [47:0] row2;
    logic [63:0] txy;
    logic [31:0] tz;
    logic [47:0] proj;
    logic [47:0] dcue;
  } cfg_t;

  // Reciprocal seed table, one byte per entry, entry 0 in the low bits.
  typedef logic [8*RecipDepth-1:0] recip_table_t;

  // Builds the seed table at elaboration; 0x40000 / (i + 0x100) is formed by
  // shift and subtract so that each entry is ((quotient + 1) / 2) - 0x101.
  function automatic recip_table_t gen_recip_table();
    recip_table_t tbl;
    logic [31:0]  den;
    logic [31:0]  rem;
    logic [31:0]  quo;
    logic [31:0]  seed;
    tbl = '0;
    for (int i = 0; i < int'(RecipDepth); i++) begin
      den = 32'(i) + 32'h100;
      rem = '0;
      quo = '0;
      for (int b = 18; b >= 0; b--) begin
        rem = {rem[30:0], (b == 18)};
        if (rem >= den) begin
          rem = rem - den;
          quo[b] = 1'b1;
        end
      end
      seed = ((quo + 32'd1) >> 1) - 32'h101;
      tbl[8*i +: 8] = seed[31] ? 8'd0 : seed[7:0];
    end
    return tbl;
  endfunction

  localparam recip_table_t RecipTable = gen_recip_table();

  // Reciprocal seed table entry.
  function automatic logic [7:0] recip_seed(input logic [8:0] idx);
    logic [8:0] i;
    i = (idx > 9'(RecipDepth - 1)) ? 9'(RecipDepth - 1) : idx;
    return RecipTable[8*i +: 8];
  endfunction

endpackage

// ===== rtl/rtp_regs.sv =====
module rtp_regs (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [5:0]        paddr,
  input  logic [63:0]       pwdata,
  output logic [63:0]       prdata,
  output rtp_pkg::cfg_t     cfg_o
);
  import rtp_pkg::*;

  cfg_t       cfg_q;
  reg_idx_e   idx;
  logic       wr;

  assign wr = psel && penable && pwrite;

  // Decode the register index from the 8-byte slot.
  always_comb begin
    unique case (paddr[5:3])
      3'd0: idx = REG_ROW0;
      3'd1: idx = REG_ROW1;
      3'd2: idx = REG_ROW2;
      3'd3: idx = REG_TXY;
      3'd4: idx = REG_TZ;
      3'd5: idx = REG_PROJ;
      3'd6: idx = REG_DCUE;
      default: idx = REG_NONE;
    endcase
  end

  // Register writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.row0 <= 48'd4096;
      cfg_q.row1 <= 48'd268435456;
      cfg_q.row2 <= 48'd17592186044416;
      cfg_q.txy  <= '0;
      cfg_q.tz   <= '0;
      cfg_q.proj <= 48'd320;
      cfg_q.dcue <= '0;
    end else if (wr) begin
      unique case (idx)
        REG_ROW0: cfg_q.row0 <= pwdata[47:0];
        REG_ROW1: cfg_q.row1 <= pwdata[47:0];
        REG_ROW2: cfg_q.row2 <= pwdata[47:0];
        REG_TXY:  cfg_q.txy  <= pwdata;
        REG_TZ:   cfg_q.tz   <= pwdata[31:0];
        REG_PROJ: cfg_q.proj <= pwdata[47:0];
        REG_DCUE: cfg_q.dcue <= pwdata[47:0];
        default: ;
      endcase
    end
  end

  // Read back.
  always_comb begin
    unique case (idx)
      REG_ROW0: prdata = {16'd0, cfg_q.row0};
      REG_ROW1: prdata = {16'd0, cfg_q.row1};
      REG_ROW2: prdata = {16'd0, cfg_q.row2};
      REG_TXY:  prdata = cfg_q.txy;
      REG_TZ:   prdata = {32'd0, cfg_q.tz};
      REG_PROJ: prdata = {16'd0, cfg_q.proj};
      REG_DCUE: prdata = {16'd0, cfg_q.dcue};
      default:  prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;
endmodule

// ===== rtl/rtp_datapath.sv =====
module rtp_datapath (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          in_valid_i,
  input  logic [15:0]   vx_i,
  input  logic [15:0]   vy_i,
  input  logic [15:0]   vz_i,
  input  logic          dcue_i,
  input  rtp_pkg::cfg_t cfg_i,
  output logic          out_valid_o,
  output logic [167:0]  out_data_o
);
  import rtp_pkg::*;

  localparam int unsigned Depth = 9;
  logic [Depth-1:0] vld_q;

  // Stage 1: nine products.
  logic signed [31:0] p1_q [3][3];
  logic signed [15:0] v_in [3];
  logic signed [47:0] rows [3];
  logic               dc1_q;

  assign v_in[0] = vx_i;
  assign v_in[1] = vy_i;
  assign v_in[2] = vz_i;
  assign rows[0] = cfg_i.row0;
  assign rows[1] = cfg_i.row1;
  assign rows[2] = cfg_i.row2;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          p1_q[r][c] <= $signed(rows[r][16*c +: 16]) * v_in[c];
        end
      end
      dc1_q <= dcue_i;
    end
  end

  // Stage 2: accumulate with translation, MAC flags.
  logic signed [45:0] acc [3];
  logic signed [31:0] mac2_q [3];
  logic [5:0]         fl2_d;
  logic [5:0]         fl2_q;
  logic               dc2_q;
  logic signed [31:0] tr [3];

  assign tr[0] = cfg_i.txy[31:0];
  assign tr[1] = cfg_i.txy[63:32];
  assign tr[2] = cfg_i.tz;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      acc[r] = 46'($signed({tr[r], 12'd0})) + 46'(p1_q[r][0]) + 46'(p1_q[r][1]) +
               46'(p1_q[r][2]);
      fl2_d[2*r]   = (acc[r] > 46'sh7FFFFFFFFFF);
      fl2_d[2*r+1] = (acc[r] < -46'sh80000000000);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int r = 0; r < 3; r++) begin
        mac2_q[r] <= acc[r][43:12];
      end
      fl2_q <= fl2_d;
      dc2_q <= dc1_q;
    end
  end

  // Stage 3: saturation and divider normalise.
  logic signed [15:0] ir1_3_q, ir2_3_q;
  logic [14:0]        ir3_3_q;
  logic [15:0]        sz_3_q;
  logic [15:0]        fl3_d;
  logic [15:0]        fl3_q;
  logic               dc3_q;
  logic               dov3_q;
  logic [15:0]        dn3_q;
  logic [16:0]        nn3_q;
  logic [15:0]        sz_c;
  logic [3:0]         lz;
  logic               divov;

  always_comb begin
    sz_c = (mac2_q[2] < 0) ? 16'd0 :
           ((mac2_q[2] > 32'sd65535) ? 16'hFFFF : mac2_q[2][15:0]);
    lz = 4'd0;
    for (int b = 0; b < 16; b++) begin
      if (sz_c[b]) lz = 4'(15 - b);
    end
    divov = (sz_c == 16'd0) || ({1'b0, cfg_i.proj[15:0]} >= {sz_c, 1'b0});
    fl3_d        = '0;
    fl3_d[5:0]   = fl2_q;
    fl3_d[FlIr1] = (mac2_q[0] < -32'sd32768) || (mac2_q[0] > 32'sd32767);
    fl3_d[FlIr2] = (mac2_q[1] < -32'sd32768) || (mac2_q[1] > 32'sd32767);
    fl3_d[FlIr3] = (mac2_q[2] < -32'sd32768) || (mac2_q[2] > 32'sd32767);
    fl3_d[FlSz]  = (mac2_q[2] < 0) || (mac2_q[2] > 32'sd65535);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      fl3_q   <= fl3_d;
      ir1_3_q <= (mac2_q[0] < -32'sd32768) ? -16'sd32768 :
                 (mac2_q[0] > 32'sd32767) ? 16'sd32767 : mac2_q[0][15:0];
      ir2_3_q <= (mac2_q[1] < -32'sd32768) ? -16'sd32768 :
                 (mac2_q[1] > 32'sd32767) ? 16'sd32767 : mac2_q[1][15:0];
      ir3_3_q <= (mac2_q[2] < 0) ? 15'd0 :
                 (mac2_q[2] > 32'sd32767) ? 15'h7FFF : mac2_q[2][14:0];
      sz_3_q  <= sz_c;
      dov3_q  <= divov;
      dn3_q   <= sz_c << lz;
      nn3_q   <= 17'({1'b0, cfg_i.proj[15:0]} << lz);
      dc3_q   <= dc2_q;
    end
  end

  // Stage 4: seed lookup.
  logic [9:0]  u4_q;
  logic [15:0] dn4_q;
  logic [16:0] nn4_q;
  logic [9:0]  u_c;
  logic [15:0] seed_idx;
  assign seed_idx = dn3_q - 16'h7FC0;
  assign u_c = 10'(recip_seed(seed_idx[15:7])) + 10'h101;

  logic signed [15:0] ir1_4_q, ir2_4_q;
  logic [14:0] ir3_4_q;
  logic [15:0] sz_4_q, fl4_q;
  logic        dc4_q, dov4_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      u4_q <= u_c; dn4_q <= dn3_q; nn4_q <= nn3_q;
      ir1_4_q <= ir1_3_q; ir2_4_q <= ir2_3_q; ir3_4_q <= ir3_3_q;
      sz_4_q <= sz_3_q; fl4_q <= fl3_q; dc4_q <= dc3_q; dov4_q <= dov3_q;
    end
  end

  // Stage 5: first Newton step.
  logic [31:0] t5;
  logic [31:0] d5_q;
  logic [9:0]  u5_q;
  logic [16:0] nn5_q;
  logic signed [15:0] ir1_5_q, ir2_5_q;
  logic [14:0] ir3_5_q;
  logic [15:0] sz_5_q, fl5_q;
  logic        dc5_q, dov5_q;

  assign t5 = (32'h2000080 - 32'(dn4_q) * 32'(u4_q)) >> 8;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d5_q <= t5; u5_q <= u4_q; nn5_q <= nn4_q;
      ir1_5_q <= ir1_4_q; ir2_5_q <= ir2_4_q; ir3_5_q <= ir3_4_q;
      sz_5_q <= sz_4_q; fl5_q <= fl4_q; dc5_q <= dc4_q; dov5_q <= dov4_q;
    end
  end

  // Stage 6: second Newton step.
  logic [31:0] t6, d6_q;
  logic [16:0] nn6_q;
  logic signed [15:0] ir1_6_q, ir2_6_q;
  logic [14:0] ir3_6_q;
  logic [15:0] sz_6_q, fl6_q;
  logic        dc6_q, dov6_q;

  assign t6 = (32'h80 + d5_q * 32'(u5_q)) >> 8;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d6_q <= t6; nn6_q <= nn5_q;
      ir1_6_q <= ir1_5_q; ir2_6_q <= ir2_5_q; ir3_6_q <= ir3_5_q;
      sz_6_q <= sz_5_q; fl6_q <= fl5_q; dc6_q <= dc5_q; dov6_q <= dov5_q;
    end
  end

  // Stage 7: quotient rounding and clamp.
  logic [48:0] q7;
  logic [16:0] quot7_d;
  logic [15:0] fl7_d;
  logic [16:0] quot7_q;
  logic signed [15:0] ir1_7_q, ir2_7_q;
  logic [14:0] ir3_7_q;
  logic [15:0] sz_7_q, fl7_q;
  logic        dc7_q;

  assign q7 = (49'(nn6_q) * 49'(d6_q) + 49'h8000) >> 16;

  always_comb begin
    fl7_d   = fl6_q;
    quot7_d = q7[16:0];
    if (dov6_q || q7 > 49'(QuotMax)) begin
      quot7_d      = QuotMax;
      fl7_d[FlDiv] = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      fl7_q <= fl7_d;
      quot7_q <= quot7_d;
      ir1_7_q <= ir1_6_q; ir2_7_q <= ir2_6_q; ir3_7_q <= ir3_6_q;
      sz_7_q <= sz_6_q; dc7_q <= dc6_q;
    end
  end

  // Stage 8: projection and depth cue products.
  logic signed [49:0] fx8_q, fy8_q, dq8_q;
  logic [16:0] quot8_q;
  logic signed [15:0] ir1_8_q, ir2_8_q;
  logic [14:0] ir3_8_q;
  logic [15:0] sz_8_q, fl8_q;
  logic        dc8_q;
  logic signed [17:0] qs;
  logic signed [33:0] px8, py8, pd8;
  assign qs  = {1'b0, quot7_q};
  assign px8 = qs * ir1_7_q;
  assign py8 = qs * ir2_7_q;
  assign pd8 = qs * $signed(cfg_i.dcue[15:0]);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      fx8_q <= 50'(px8) + 50'($signed({cfg_i.proj[31:16], 16'd0}));
      fy8_q <= 50'(py8) + 50'($signed({cfg_i.proj[47:32], 16'd0}));
      dq8_q <= 50'(pd8) + 50'($signed(cfg_i.dcue[47:16]));
      quot8_q <= quot7_q;
      ir1_8_q <= ir1_7_q; ir2_8_q <= ir2_7_q; ir3_8_q <= ir3_7_q;
      sz_8_q <= sz_7_q; fl8_q <= fl7_q; dc8_q <= dc7_q;
    end
  end

  // Stage 9: final clamps and flags.
  logic signed [33:0] sxf, syf;
  logic signed [37:0] irf;
  logic [15:0]        fl9;
  logic [10:0]        sx9, sy9;
  logic [31:0]        dv9;
  logic [12:0]        ir09;
  logic [167:0]       out_q;

  always_comb begin
    sxf = fx8_q[49:16];
    syf = fy8_q[49:16];
    irf = dq8_q[49:12];
    fl9 = fl8_q;
    if (fx8_q > 50'sh7FFFFFFF || fy8_q > 50'sh7FFFFFFF) fl9[FlMac0P] = 1'b1;
    if (fx8_q < -50'sh80000000 || fy8_q < -50'sh80000000) fl9[FlMac0N] = 1'b1;
    if (sxf < -34'sd1024) begin sx9 = 11'h400; fl9[FlSx] = 1'b1; end
    else if (sxf > 34'sd1023) begin sx9 = 11'h3FF; fl9[FlSx] = 1'b1; end
    else sx9 = sxf[10:0];
    if (syf < -34'sd1024) begin sy9 = 11'h400; fl9[FlSy] = 1'b1; end
    else if (syf > 34'sd1023) begin sy9 = 11'h3FF; fl9[FlSy] = 1'b1; end
    else sy9 = syf[10:0];
    dv9 = '0;
    ir09 = '0;
    if (dc8_q) begin
      if (dq8_q > 50'sh7FFFFFFF) fl9[FlMac0P] = 1'b1;
      if (dq8_q < -50'sh80000000) fl9[FlMac0N] = 1'b1;
      dv9 = dq8_q[31:0];
      if (irf < 0) begin ir09 = 13'd0; fl9[FlIr0] = 1'b1; end
      else if (irf > 38'sd4096) begin ir09 = 13'd4096; fl9[FlIr0] = 1'b1; end
      else ir09 = irf[12:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      out_q <= {5'd0, fl9, ir09, dv9, quot8_q, ir3_8_q, ir2_8_q, ir1_8_q, sz_8_q,
                sy9, sx9};
    end
  end

  // Valid bits travel alongside.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else if (en_i) vld_q <= {vld_q[Depth-2:0], in_valid_i};
  end

  assign out_valid_o = vld_q[Depth-1];
  assign out_data_o  = out_q;
endmodule

// ===== rtl/rotate_translate_perspective_core.sv =====
// Nine register stages lie between an accepted input request and its presented
// result, the first capturing the input.
// Throughput: one vertex per cycle; the whole pipeline holds when the output stalls.
// Stages: 3x3 multiply, accumulate, saturate/normalise, seed, two Newton steps,
// quotient, projection multiply, clamp.
// Reset: rst_ni is asynchronous active low; clears valid bits, config registers go to defaults.
module rotate_translate_perspective_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [47:0]   s_axis_tdata,   // vertex_x, vertex_y, vertex_z
  input  logic          s_axis_tuser,   // run_depth_cue
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [167:0]  m_axis_tdata,   // screen_x, screen_y, screen_z, view_x, view_y,
                                        // view_z, reciprocal_quotient, depth_cue_value,
                                        // depth_cue_factor, flags
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [5:0]    paddr,
  input  logic [63:0]   pwdata,
  output logic [63:0]   prdata,
  output logic          pready
);
  import rtp_pkg::*;
  `include "rotate_translate_perspective_core_defines.svh"

  cfg_t cfg;
  logic en;

  assign pready = 1'b1;
  // Pipeline advances unless a valid result is held at the output.
  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  rtp_regs u_regs (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata,
    .cfg_o(cfg)
  );

  rtp_datapath u_dp (
    .clk_i, .rst_ni,
    .en_i(en),
    .in_valid_i(s_axis_tvalid),
    .vx_i(s_axis_tdata[15:0]),
    .vy_i(s_axis_tdata[31:16]),
    .vz_i(s_axis_tdata[47:32]),
    .dcue_i(s_axis_tuser),
    .cfg_i(cfg),
    .out_valid_o(m_axis_tvalid),
    .out_data_o(m_axis_tdata)
  );

  `RTP_ASSERT(a_ir0_range, clk_i, rst_ni, !m_axis_tvalid || m_axis_tdata[146:134] <= 13'd4096, "depth cue factor out of range")
  `RTP_ASSERT_NEXT(a_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")
  `RTP_ASSERT(a_ready, clk_i, rst_ni, s_axis_tready == (!m_axis_tvalid || m_axis_tready), "ready does not follow output stall")
endmodule
